### hdl/arp_pkg.sv
// Package for the ARP resolver: operation codes, action codes, queue command
// and result structs. No dependencies.
`default_nettype none
package arp_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_RX     = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PRO_IPV4    = 16'h0800;
    localparam logic [7:0]  HW_LEN_MAC  = 8'd6;
    localparam logic [7:0]  PRO_LEN_IP  = 8'd4;
    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;
    localparam logic [15:0] PROTO_ARP   = 16'h0806;
    localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

    localparam logic CFG_LOCAL_IP = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_SEND    = 3'd1,
        ACT_BCAST   = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_REPLY   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        K_NOP,
        K_TICK,
        K_RX,
        K_LOOKUP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        reply_req;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
        logic [31:0] tgt_ip;
        logic [15:0] upper_protocol;
    } t_cmd;

    typedef struct packed {
        t_action     action;
        logic [47:0] dest_mac;
        logic [31:0] dest_ip;
        logic [15:0] out_protocol;
    } t_result;

endpackage
`default_nettype wire

### hdl/arp_if.sv
// Valid/ready channel interfaces for the ARP resolver: request and response.
// No dependencies.
`default_nettype none
interface arp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  pro_len;
    logic [15:0] opcode;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [31:0] tgt_ip;
    logic [15:0] upper_protocol;

    modport source (output valid, operation, hw_type, proto_type, hw_len, pro_len,
                    opcode, src_ip, src_mac, tgt_ip, upper_protocol,
                    input ready);
    modport sink (input valid, operation, hw_type, proto_type, hw_len, pro_len,
                  opcode, src_ip, src_mac, tgt_ip, upper_protocol,
                  output ready);
endinterface

interface arp_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [47:0] dest_mac;
    logic [31:0] dest_ip;
    logic [15:0] out_protocol;

    modport source (output valid, action, dest_mac, dest_ip, out_protocol,
                    input ready);
    modport sink (input valid, action, dest_mac, dest_ip, out_protocol,
                  output ready);
endinterface
`default_nettype wire

### hdl/arp_front.sv
// Front end: accepts requests, checks ARP headers and classifies them.
// Depends on arp_pkg and arp_req_if.
`default_nettype none
module arp_front
    import arp_pkg::*;
(
    arp_req_if.sink    i_req,
    input  wire [31:0] i_local_ip,
    input  wire        i_q_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic hdr_ok;

    always_comb begin
        hdr_ok = (i_req.hw_type == HW_ETHERNET) && (i_req.proto_type == PRO_IPV4) &&
                 (i_req.hw_len == HW_LEN_MAC) && (i_req.pro_len == PRO_LEN_IP) &&
                 ((i_req.opcode == OPC_REQUEST) || (i_req.opcode == OPC_REPLY));
        o_cmd.src_ip         = i_req.src_ip;
        o_cmd.src_mac        = i_req.src_mac;
        o_cmd.tgt_ip         = i_req.tgt_ip;
        o_cmd.upper_protocol = i_req.upper_protocol;
        o_cmd.reply_req      = (i_req.opcode == OPC_REQUEST) &&
                               (i_req.tgt_ip == i_local_ip);
        case (i_req.operation)
            OP_TICK:   o_cmd.kind = K_TICK;
            OP_RX:     o_cmd.kind = hdr_ok ? K_RX : K_NOP;
            OP_LOOKUP: o_cmd.kind = K_LOOKUP;
            default:   o_cmd.kind = K_NOP;
        endcase
    end

    assign i_req.ready = i_q_ready;
    assign o_push      = i_req.valid && i_q_ready;

endmodule
`default_nettype wire

### hdl/arp_queue.sv
// Two-entry command queue between front and back end.
// Depends on arp_pkg.
`default_nettype none
module arp_queue
    import arp_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  wire  i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_cmd;
                r_wr        <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/arp_back.sv
// Back end: table scans for learning and lookup, pending slot, clock of
// seconds and the response register. Depends on arp_pkg and arp_rsp_if.
`default_nettype none
module arp_back
    import arp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire [15:0] i_timeout,
    input  wire        i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    arp_rsp_if.source  o_rsp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LSCAN,
        S_LWRITE,
        S_FSCAN,
        S_RESULT
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [31:0] r_key;

    logic [31:0] mem_ip    [TABLE_ENTRIES];
    logic [47:0] mem_mac   [TABLE_ENTRIES];
    logic [31:0] mem_stamp [TABLE_ENTRIES];
    logic [31:0] r_rd_ip;
    logic [47:0] r_rd_mac;
    logic [31:0] r_rd_stamp;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0] r_idx;
    logic             r_issue;
    logic [IDX_W-1:0] r_didx;
    logic             r_dvalid;

    logic [31:0] r_now;
    logic        r_pend;
    logic [15:0] r_pend_proto;

    logic             r_have_free;
    logic [IDX_W-1:0] r_free;
    logic             r_have_old;
    logic [IDX_W-1:0] r_old;
    logic [31:0]      r_oldest;

    logic        r_hit;
    logic [47:0] r_hit_mac;

    t_result r_res;
    logic    r_ovalid;
    t_result r_out;

    logic        cur_valid;
    logic [31:0] age;
    logic        expired;
    logic        last_d;
    logic        match;
    logic        f_hit;
    logic [47:0] f_mac;

    always_comb begin
        cur_valid = r_valid[r_didx];
        age       = r_now - r_rd_stamp;
        expired   = age > {16'd0, i_timeout};
        last_d    = r_dvalid && (r_didx == LAST);
        match     = cur_valid && (r_rd_ip == r_key);
        f_hit     = r_hit || match;
        f_mac     = r_hit ? r_hit_mac : r_rd_mac;
        mem_we    = (r_state == S_LWRITE);
        mem_waddr = r_have_free ? r_free : r_old;
        o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.action       = r_out.action;
    assign o_rsp.dest_mac     = r_out.dest_mac;
    assign o_rsp.dest_ip      = r_out.dest_ip;
    assign o_rsp.out_protocol = r_out.out_protocol;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_ip[mem_waddr]    <= r_cmd.src_ip;
            mem_mac[mem_waddr]   <= r_cmd.src_mac;
            mem_stamp[mem_waddr] <= r_now;
        end
        r_rd_ip    <= mem_ip[r_idx];
        r_rd_mac   <= mem_mac[r_idx];
        r_rd_stamp <= mem_stamp[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_issue      <= 1'b0;
            r_dvalid     <= 1'b0;
            r_idx        <= '0;
            r_now        <= '0;
            r_pend       <= 1'b0;
            r_pend_proto <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            // scan address pipeline, one entry a cycle
            r_didx   <= r_idx;
            r_dvalid <= r_issue;
            if (r_issue) begin
                if (r_idx == LAST) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end

            if (o_rsp.valid && o_rsp.ready && (r_state != S_RESULT)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_res <= '{ACT_NONE, 48'd0, 32'd0, 16'd0};
                    if (i_q_valid) begin
                        r_cmd       <= i_q_cmd;
                        r_idx       <= '0;
                        r_have_free <= 1'b0;
                        r_have_old  <= 1'b0;
                        r_free      <= '0;
                        r_old       <= '0;
                        r_oldest    <= '0;
                        r_hit       <= 1'b0;
                        r_hit_mac   <= '0;
                        case (i_q_cmd.kind)
                            K_TICK: begin
                                r_now   <= r_now + 1'b1;
                                r_state <= S_RESULT;
                            end
                            K_RX: begin
                                r_key   <= i_q_cmd.src_ip;
                                r_issue <= 1'b1;
                                r_state <= S_LSCAN;
                            end
                            K_LOOKUP: begin
                                r_key   <= i_q_cmd.tgt_ip;
                                r_issue <= 1'b1;
                                r_state <= S_FSCAN;
                            end
                            default: r_state <= S_RESULT;
                        endcase
                    end
                end
                S_LSCAN: begin
                    if (r_dvalid) begin
                        if (!cur_valid) begin
                            r_have_free <= 1'b1;
                            r_free      <= r_didx;
                        end else if (expired) begin
                            r_valid[r_didx] <= 1'b0;
                            r_have_free     <= 1'b1;
                            r_free          <= r_didx;
                        end else if (!r_have_old || (age > r_oldest)) begin
                            r_have_old <= 1'b1;
                            r_oldest   <= age;
                            r_old      <= r_didx;
                        end
                    end
                    if (last_d) begin
                        r_state <= S_LWRITE;
                    end
                end
                S_LWRITE: begin
                    r_valid[mem_waddr] <= 1'b1;
                    if (r_pend) begin
                        r_pend  <= 1'b0;
                        r_res   <= '{ACT_RELEASE, r_cmd.src_mac, 32'd0, r_pend_proto};
                        r_state <= S_RESULT;
                    end else if (r_cmd.reply_req) begin
                        r_idx   <= '0;
                        r_issue <= 1'b1;
                        r_state <= S_FSCAN;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_FSCAN: begin
                    if (r_dvalid && match && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_mac <= r_rd_mac;
                    end
                    if (last_d) begin
                        r_state <= S_RESULT;
                        if (r_cmd.kind == K_RX) begin
                            r_res <= '{ACT_REPLY, f_mac, r_cmd.src_ip, PROTO_ARP};
                        end else if (f_hit) begin
                            r_res <= '{ACT_SEND, f_mac, 32'd0, r_cmd.upper_protocol};
                        end else begin
                            r_res <= '{ACT_BCAST, MAC_BCAST, r_cmd.tgt_ip, PROTO_ARP};
                            r_pend       <= 1'b1;
                            r_pend_proto <= r_cmd.upper_protocol;
                        end
                    end
                end
                S_RESULT: begin
                    // hold until the response register is free
                    if (!r_ovalid || o_rsp.ready) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/arp_cache_resolver_unit.sv
// Top level of the ARP resolver: configuration registers, front end, command
// queue and back end. Depends on arp_pkg, arp_if, arp_front, arp_queue, arp_back.
//
//  channel   direction  handshake           payload
//  i_req     in         valid/ready         operation, ARP header, addresses
//  o_rsp     out        valid/ready         action, dest_mac, dest_ip, protocol
//  i_cfg_*   in         write enable only   register index, 32-bit data
//
// The back-end sequencer scans the table one entry a cycle through a registered
// memory port. A tick or a rejected header goes straight to the response; a
// lookup makes one scan; a received packet makes a learning scan and a write;
// a received request for the local IP adds a lookup scan after the write unless
// a pending request is released instead.
// Reset clears the valid bits at once; there is no clearing pass.
// A full response register stalls only the back end; the two-entry queue
// keeps accepting requests until it fills.
`default_nettype none
module arp_cache_resolver_unit
    import arp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    arp_req_if.sink    i_req,
    arp_rsp_if.source  o_rsp,
    input  wire        i_cfg_we,
    input  wire        i_cfg_index,
    input  wire [31:0] i_cfg_data
);

    logic [31:0] r_local_ip;
    logic [15:0] r_timeout;

    logic q_push;
    logic q_ready;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // configuration writes take effect at once; write only with no request in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0;
            r_timeout  <= 16'd60;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOCAL_IP: r_local_ip <= i_cfg_data;
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[15:0];
                default:      r_local_ip <= r_local_ip;
            endcase
        end
    end

    // classify each request and push it into the queue
    arp_front u_front (
        .i_req      (i_req),
        .i_local_ip (r_local_ip),
        .i_q_ready  (q_ready),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    // decouple front and back end
    arp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // carry out table scans and drive the response register
    arp_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_timeout (r_timeout),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_rsp     (o_rsp)
    );

endmodule
`default_nettype wire
